@@ src/tcw_pkg.sv @@
`timescale 1ns / 1ps

package tcw_pkg;

  // item field types
  typedef logic [1:0]  kind_t;
  typedef logic [7:0]  byte_t;
  typedef logic [10:0] index_t;
  typedef logic [15:0] cell_t;
  typedef logic [3:0]  count_t;

  // item kinds
  localparam kind_t KIND_WRITE = 2'd0;
  localparam kind_t KIND_CLEAR = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_TEXT_ATTR  = 2'd0;
  localparam logic [1:0] REG_CLEAR_ATTR = 2'd1;
  localparam logic [1:0] REG_TAB_WIDTH  = 2'd2;

  // register reset values
  localparam byte_t  TEXT_ATTR_RESET  = 8'h0F;
  localparam byte_t  CLEAR_ATTR_RESET = 8'h00;
  localparam count_t TAB_WIDTH_RESET  = 4'd4;

  // character codes
  localparam byte_t CODE_SPACE   = 8'h20;
  localparam byte_t CODE_TAB     = 8'h09;
  localparam byte_t CODE_NEWLINE = 8'h0A;

  // longest tab in spaces
  localparam count_t TAB_LIMIT = 4'd8;

  // width of the config data port
  localparam int CFG_W = 8;

endpackage

@@ src/tcw_if.sv @@
`timescale 1ns / 1ps

// request channel: one console item
interface tcw_req_if;
  logic                 valid;
  logic                 ready;
  tcw_pkg::kind_t       kind;
  tcw_pkg::byte_t       char_code;
  tcw_pkg::index_t      cell_index;

  modport source (output valid, output kind, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input kind, input char_code, input cell_index,
                  output ready);
endinterface

// response channel: one result per item
interface tcw_rsp_if;
  logic                 valid;
  logic                 ready;
  tcw_pkg::cell_t       cell_value;
  tcw_pkg::index_t      cursor_position;
  logic                 scrolled;

  modport source (output valid, output cell_value, output cursor_position,
                  output scrolled, input ready);
  modport sink   (input valid, input cell_value, input cursor_position,
                  input scrolled, output ready);
endinterface

@@ src/tcw_ram.sv @@
`timescale 1ns / 1ps

// screen store: one write port, one read port with registered data
module tcw_ram #(
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  tcw_pkg::cell_t wdata,
  input  logic [AW-1:0]  raddr,
  output tcw_pkg::cell_t rdata
);

  tcw_pkg::cell_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/text_console_writer.sv @@
`timescale 1ns / 1ps

// Teletype writer for a ROWS x COLUMNS text screen of 16-bit cells (attribute
// high byte, character low byte), kept in one single-port-write, single-port-
// read memory and walked by an address sequencer. One item at a time; every
// item gives one response. A scroll moves ROWS-1 rows up and blanks the bottom
// row; both share the one memory write port, one cell per cycle. A response
// that is not taken holds the block in its result state until the previous one
// leaves. After reset the memory is swept to zero before the first request is
// taken; config writes are taken at any time the block is idle.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]     cfg_data,
  tcw_req_if.sink                       req,
  tcw_rsp_if.source                     rsp
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_START = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

  typedef enum logic [9:0] {
    S_WIPE  = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_PUT   = 10'b00_0000_0100,
    S_COPY  = 10'b00_0000_1000,
    S_DRAIN = 10'b00_0001_0000,
    S_BLANK = 10'b00_0010_0000,
    S_FILL  = 10'b00_0100_0000,
    S_READ  = 10'b00_1000_0000,
    S_RDATA = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state;

  // configuration
  tcw_pkg::byte_t  text_attr;
  tcw_pkg::byte_t  clear_attr;
  tcw_pkg::count_t tab_width;

  // console state
  logic [AW-1:0]   cursor;
  logic [CW-1:0]   col;

  // per-item working registers
  tcw_pkg::index_t idx_q;
  tcw_pkg::byte_t  put_code;
  tcw_pkg::count_t cnt;
  logic            line_mode;
  logic            more_after;
  logic            scrolled_q;
  tcw_pkg::cell_t  value_q;
  logic [AW-1:0]   scan;
  logic [AW-1:0]   cp_dst;
  logic            cp_vld;

  // response register
  logic            rsp_valid;
  tcw_pkg::cell_t  rsp_value;
  tcw_pkg::index_t rsp_cursor;
  logic            rsp_scrolled;

  // memory port
  logic            we;
  logic [AW-1:0]   waddr;
  tcw_pkg::cell_t  wdata;
  logic [AW-1:0]   raddr;
  tcw_pkg::cell_t  rdata;

  logic            req_fire;
  logic            more;
  logic            in_range;
  tcw_pkg::count_t tab_n;

  assign req.ready     = (state == S_IDLE);
  assign req_fire      = req.valid && req.ready;
  assign rsp.valid       = rsp_valid;
  assign rsp.cell_value  = rsp_value;
  assign rsp.cursor_position = rsp_cursor;
  assign rsp.scrolled    = rsp_scrolled;

  // tab length clipped to the limit
  assign tab_n = (tab_width > tcw_pkg::TAB_LIMIT) ? tcw_pkg::TAB_LIMIT : tab_width;

  // another cell follows this one in the same item
  assign more = line_mode ? (col != COL_LAST) : (cnt != 4'd1);

  assign in_range = (32'(req.cell_index) < 32'(CELLS));

  tcw_ram #(.DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // memory port steering
  always_comb begin
    we    = 1'b0;
    waddr = scan;
    wdata = '0;
    raddr = scan;
    unique case (state)
      S_WIPE: begin
        we = 1'b1;
      end
      S_FILL: begin
        we    = 1'b1;
        wdata = {clear_attr, tcw_pkg::CODE_SPACE};
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = cursor;
        wdata = {text_attr, put_code};
      end
      S_COPY, S_DRAIN: begin
        we    = cp_vld;
        waddr = cp_dst;
        wdata = rdata;
      end
      S_BLANK: begin
        we    = 1'b1;
        wdata = {text_attr, tcw_pkg::CODE_SPACE};
      end
      S_READ: begin
        raddr = AW'(idx_q);
      end
      default: begin
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr  <= tcw_pkg::TEXT_ATTR_RESET;
      clear_attr <= tcw_pkg::CLEAR_ATTR_RESET;
      tab_width  <= tcw_pkg::TAB_WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcw_pkg::REG_TEXT_ATTR:  text_attr  <= cfg_data[7:0];
        tcw_pkg::REG_CLEAR_ATTR: clear_attr <= cfg_data[7:0];
        tcw_pkg::REG_TAB_WIDTH:  tab_width  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WIPE;
      scan      <= '0;
      cursor    <= '0;
      col       <= '0;
      cp_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // response transfer frees the register unless a new result loads it
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        // power-up sweep of the screen to zero
        S_WIPE: begin
          if (scan == LAST_CELL) begin
            state <= S_IDLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            idx_q      <= req.cell_index;
            scrolled_q <= 1'b0;
            value_q    <= '0;
            line_mode  <= 1'b0;
            cnt        <= 4'd1;
            put_code   <= tcw_pkg::CODE_SPACE;
            scan       <= '0;
            unique case (req.kind)
              tcw_pkg::KIND_WRITE: begin
                if (req.char_code == tcw_pkg::CODE_TAB) begin
                  cnt   <= tab_n;
                  state <= (tab_n == '0) ? S_DONE : S_PUT;
                end else if (req.char_code == tcw_pkg::CODE_NEWLINE) begin
                  line_mode <= 1'b1;
                  state     <= S_PUT;
                end else begin
                  put_code <= req.char_code;
                  state    <= S_PUT;
                end
              end
              tcw_pkg::KIND_CLEAR: state <= S_FILL;
              tcw_pkg::KIND_READ:  state <= in_range ? S_READ : S_DONE;
              default:             state <= S_DONE;
            endcase
          end
        end
        // one cell written at the cursor, then advance
        S_PUT: begin
          cnt <= cnt - 1'b1;
          if (cursor == LAST_CELL) begin
            cursor     <= ROW_START;
            col        <= '0;
            scrolled_q <= 1'b1;
            more_after <= more;
            scan       <= ROW_STEP;
            cp_vld     <= 1'b0;
            state      <= S_COPY;
          end else begin
            cursor <= cursor + 1'b1;
            col    <= (col == COL_LAST) ? '0 : col + 1'b1;
            state  <= more ? S_PUT : S_DONE;
          end
        end
        // move rows up: read one row ahead, write the previous read
        S_COPY: begin
          cp_vld <= 1'b1;
          cp_dst <= scan - ROW_STEP;
          if (scan == LAST_CELL) begin
            state <= S_DRAIN;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_DRAIN: begin
          cp_vld <= 1'b0;
          scan   <= ROW_START;
          state  <= S_BLANK;
        end
        // blank the bottom row
        S_BLANK: begin
          if (scan == LAST_CELL) begin
            state <= more_after ? S_PUT : S_DONE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        // clear the whole screen
        S_FILL: begin
          if (scan == LAST_CELL) begin
            state <= S_DONE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_READ: begin
          state <= S_RDATA;
        end
        S_RDATA: begin
          value_q <= rdata;
          state   <= S_DONE;
        end
        // hand the result to the response register once it is free
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid    <= 1'b1;
            rsp_value    <= value_q;
            rsp_cursor   <= 11'(cursor);
            rsp_scrolled <= scrolled_q;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= LAST_CELL)
    else $error("cursor beyond last cell");

  // writing the last cell always starts a scroll at the bottom row start
  a_scroll_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT && cursor == LAST_CELL) |=>
      (state == S_COPY && cursor == ROW_START && col == '0 && scrolled_q))
    else $error("scroll did not start after last cell");

  // a new response is only loaded from the result state
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("response raised outside result state");

  // column tracks the cursor at the start of a row
  a_col_row_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_BLANK) |-> (col == '0 && cursor == ROW_START))
    else $error("column and cursor disagree after scroll");

endmodule
